@@ sv/card_whitelist_enroll_defines.svh @@
// Assertion helpers used by the RTL of the card whitelist block.
`ifndef CARD_WHITELIST_ENROLL_DEFINES_SVH
`define CARD_WHITELIST_ENROLL_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CWE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cwe_pkg.sv @@
`timescale 1ns / 1ps

package cwe_pkg;

  localparam int unsigned SLOTS_DEF = 256;
  localparam logic [31:0] MASTER_CARD_RST = 32'h2322_9F6C;
  localparam logic [31:0] ENROL_WINDOW_RST = 32'd10000;

  typedef enum logic [0:0] {
    CMD_CARD = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_MASTER_CARD  = 1'b0,
    CFG_ENROL_WINDOW = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_DOOR   = 3'd1,
    ST_ENROL  = 3'd2,
    ST_KNOWN  = 3'd3,
    ST_ADDED  = 3'd4,
    ST_FULL   = 3'd5,
    ST_LOADED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] card_id;
    logic [31:0] now_ms;
    logic [7:0]  load_slot;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        door_open;
    logic        enrolling;
    logic [7:0]  slot_used;
  } out_item_t;

endpackage

@@ sv/cwe_slot_ram.sv @@
`timescale 1ns / 1ps

module cwe_slot_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/card_whitelist_enroll.sv @@
`timescale 1ns / 1ps
`include "card_whitelist_enroll_defines.svh"

// Card whitelist with an enrol window. After reset the block sweeps the slot memory to zero,
// one slot per cycle, and takes no beat until the sweep is done; configuration writes are
// taken at any time. A card beat walks the slot memory through its single read port, one
// slot per cycle, and stops at the first slot that decides the result. One beat is in work
// at a time; a new beat is taken while the previous result still waits at the output
// register.

module card_whitelist_enroll #(
  parameter int unsigned SLOTS = cwe_pkg::SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cwe_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cwe_pkg::out_item_t   out_item_o
);

  import cwe_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  fsm_e state_q, state_d;
  logic [31:0] master_q, window_q;
  logic [SW-1:0] clr_idx_q, clr_idx_d;
  logic [SW-1:0] rd_idx_q, rd_idx_d;
  logic [SW-1:0] chk_idx_q, chk_idx_d;
  logic chk_v_q, chk_v_d;
  logic [31:0] card_q, card_d;
  logic is_master_q, is_master_d;
  logic door_q, door_d;
  logic enrol_q, enrol_d;
  logic [31:0] start_q, start_d;
  out_item_t res_q, res_d;
  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic mem_we;
  logic [SW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, mem_rdata;

  logic in_range, card_master, win_active;
  logic [31:0] start_eff, elapsed;
  logic ent_used, ent_hit, scan_fin;
  status_e scan_st;
  logic [7:0] scan_slot;

  cwe_slot_ram #(
    .DEPTH(SLOTS),
    .AW   (SW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= MASTER_CARD_RST;
      window_q <= ENROL_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MASTER_CARD:  master_q <= cfg_wdata_i;
        CFG_ENROL_WINDOW: window_q <= cfg_wdata_i;
        default:          master_q <= master_q;
      endcase
    end
  end

  assign in_range    = 32'(in_item_i.load_slot) < 32'(SLOTS);
  assign card_master = in_item_i.card_id == master_q;
  assign start_eff   = card_master ? in_item_i.now_ms : start_q;
  assign elapsed     = in_item_i.now_ms - start_eff;
  assign win_active  = (card_master || enrol_q) && !(elapsed > window_q);

  assign ent_used = mem_rdata[7:0] != 8'd0;
  assign ent_hit  = ent_used && (mem_rdata == card_q);

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    rd_idx_d    = rd_idx_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = rd_idx_q;
    card_d      = card_q;
    is_master_d = is_master_q;
    door_d      = door_q;
    enrol_d     = enrol_q;
    start_d     = start_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = clr_idx_q;
    mem_wdata   = '0;
    mem_raddr   = rd_idx_q;
    in_ready_o  = 1'b0;
    scan_fin    = 1'b0;
    scan_st     = ST_NONE;
    scan_slot   = 8'd0;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx_q == LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + SW'(1);
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_item_i.cmd == CMD_LOAD) begin
            res_d = '{status: ST_NONE, door_open: door_q, enrolling: enrol_q, slot_used: 8'd0};
            if (in_range) begin
              mem_we          = 1'b1;
              mem_waddr       = SW'(in_item_i.load_slot);
              mem_wdata       = in_item_i.card_id;
              res_d.status    = ST_LOADED;
              res_d.slot_used = in_item_i.load_slot;
            end
            state_d = S_DONE;
          end else begin
            card_d      = in_item_i.card_id;
            is_master_d = card_master;
            start_d     = start_eff;
            enrol_d     = win_active;
            rd_idx_d    = '0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_idx_q != LAST) begin
          rd_idx_d = rd_idx_q + SW'(1);
        end
        chk_v_d = 1'b1;
        if (chk_v_q) begin
          if (enrol_q) begin
            if (ent_hit) begin
              scan_fin = 1'b1;
              scan_st  = ST_KNOWN;
            end else if (!ent_used) begin
              scan_fin  = 1'b1;
              scan_st   = ST_ADDED;
              scan_slot = 8'(chk_idx_q);
              mem_we    = 1'b1;
              mem_waddr = chk_idx_q;
              mem_wdata = card_q;
            end else if (chk_idx_q == LAST) begin
              scan_fin = 1'b1;
              scan_st  = ST_FULL;
            end
          end else begin
            if (ent_hit) begin
              scan_fin = 1'b1;
              scan_st  = ST_DOOR;
              door_d   = !door_q;
            end else if (chk_idx_q == LAST) begin
              scan_fin = 1'b1;
              scan_st  = ST_NONE;
            end
          end
          if (scan_fin) begin
            chk_v_d = 1'b0;
            state_d = S_DONE;
            res_d   = '{status: is_master_q ? ST_ENROL : scan_st, door_open: door_d,
                        enrolling: enrol_q, slot_used: scan_slot};
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      rd_idx_q    <= '0;
      chk_v_q     <= 1'b0;
      door_q      <= 1'b1;
      enrol_q     <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      rd_idx_q    <= rd_idx_d;
      chk_v_q     <= chk_v_d;
      door_q      <= door_d;
      enrol_q     <= enrol_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    card_q      <= card_d;
    is_master_q <= is_master_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `CWE_ASSERT_NEXT(a_card_starts_scan, in_valid_i && in_ready_o && in_item_i.cmd == CMD_CARD, state_q == S_SCAN, "Accepted card beat did not start a slot scan.")
  `CWE_ASSERT_NOW(a_scan_write_enrol, state_q == S_SCAN && mem_we, enrol_q, "Slot written during a scan outside the enrol window.")
  `CWE_ASSERT_NOW(a_door_from_scan, !$stable(door_q), $past(state_q) == S_SCAN && !$past(enrol_q), "Door flag changed outside a non-enrolling scan.")
  `CWE_ASSERT_NOW(a_enrol_status, out_valid_o && out_item_o.status == ST_ENROL, out_item_o.enrolling, "Enrol status reported with the enrol window closed.")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import cwe_pkg::*;

  localparam int NSLOTS = SLOTS_DEF;
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = CFG_MASTER_CARD;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;

  // Whitelist state and registers as the block should hold them.
  logic [31:0] slot_mem [NSLOTS];
  logic        door_q = 1'b1;
  logic        enrol_on = 1'b0;
  logic [31:0] enrol_t0 = '0;
  logic [31:0] master_id = MASTER_CARD_RST;
  logic [31:0] window_ms = ENROL_WINDOW_RST;

  in_item_t    pending_items [$];
  out_item_t   expected_results [$];
  logic [31:0] id_pool [$];
  logic [31:0] clock_ms = '0;

  int tx_gap = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_stall = 0;
  int rx_calm = 0;
  int rx_beats = 0;
  int rx_pick;
  int mismatches = 0;
  int cycles = 0;
  out_item_t want;

  card_whitelist_enroll #(
    .SLOTS(NSLOTS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      slot_mem[i] = '0;
    end
  end

  function automatic out_item_t predict_whitelist(input in_item_t it);
    out_item_t res;
    logic      is_master;
    logic      hit;
    res.status = ST_NONE;
    res.slot_used = '0;
    hit = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      if (int'(it.load_slot) < NSLOTS) begin
        slot_mem[it.load_slot] = it.card_id;
        res.status = ST_LOADED;
        res.slot_used = it.load_slot;
      end
    end else begin
      is_master = (it.card_id == master_id);
      if (is_master) begin
        enrol_t0 = it.now_ms;
        enrol_on = 1'b1;
      end
      if (enrol_on && (it.now_ms - enrol_t0) > window_ms) begin
        enrol_on = 1'b0;
      end
      if (!enrol_on) begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (!hit && slot_mem[i][7:0] != 8'h00 && slot_mem[i] == it.card_id) begin
            hit = 1'b1;
            door_q = !door_q;
            res.status = ST_DOOR;
          end
        end
      end else begin
        res.status = ST_FULL;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!hit) begin
            if (slot_mem[i][7:0] != 8'h00) begin
              if (slot_mem[i] == it.card_id) begin
                hit = 1'b1;
                res.status = ST_KNOWN;
              end
            end else begin
              // A card with a zero first byte is written here but leaves the slot free.
              slot_mem[i] = it.card_id;
              hit = 1'b1;
              res.status = ST_ADDED;
              res.slot_used = i[7:0];
            end
          end
        end
      end
      if (is_master) begin
        res.status = ST_ENROL;
      end
    end
    res.door_open = door_q;
    res.enrolling = enrol_on;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatches < 50) begin
      $display("mismatch at result beat %0d: %s got %0h, expected %0h",
               rx_beats, what, got, exp_val);
    end
    mismatches++;
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end
    if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(30, 150);
  endfunction

  function automatic int next_gap();
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      tx_calm = $urandom_range(20, 80);
      return 0;
    end
    return ($urandom_range(0, 1) == 0) ? 0 : pick_idle();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_whitelist(in_item));
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          tx_gap = next_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rx_beats++;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", 32'(out_item), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.status != want.status) begin
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          end
          if (out_item.door_open != want.door_open) begin
            report_mismatch("door_open", 32'(out_item.door_open), 32'(want.door_open));
          end
          if (out_item.enrolling != want.enrolling) begin
            report_mismatch("enrolling", 32'(out_item.enrolling), 32'(want.enrolling));
          end
          if (out_item.slot_used != want.slot_used) begin
            report_mismatch("slot_used", 32'(out_item.slot_used), 32'(want.slot_used));
          end
        end
        // Hold the output off long enough for the block to back up its input.
        if (rx_beats % 500 == 250) begin
          rx_hold = 700;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if (rx_calm > 0) begin
        rx_calm--;
        out_ready <= 1'b1;
      end else begin
        rx_pick = $urandom_range(0, 39);
        if (rx_pick == 0) begin
          rx_calm = $urandom_range(20, 100);
        end else if (rx_pick < 8) begin
          rx_stall = pick_idle();
        end
        out_ready <= (rx_stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void push_card(input logic [31:0] id, input logic [31:0] now);
    in_item_t it;
    it.cmd = CMD_CARD;
    it.card_id = id;
    it.now_ms = now;
    it.load_slot = 8'($urandom_range(0, 255));
    pending_items.push_back(it);
  endfunction

  function automatic void push_load(input logic [7:0] slot, input logic [31:0] id);
    in_item_t it;
    it.cmd = CMD_LOAD;
    it.card_id = id;
    it.now_ms = $urandom();
    it.load_slot = slot;
    pending_items.push_back(it);
  endfunction

  function automatic logic [31:0] fresh_id();
    logic [31:0] id;
    id = $urandom();
    if (id[7:0] == 8'h00) begin
      id[7:0] = 8'hA5;
    end
    id_pool.push_back(id);
    if (id_pool.size() > 64) begin
      id_pool.delete($urandom_range(0, id_pool.size() - 1));
    end
    return id;
  endfunction

  function automatic logic [31:0] pool_pick();
    if (id_pool.size() == 0) begin
      return fresh_id();
    end
    return id_pool[$urandom_range(0, id_pool.size() - 1)];
  endfunction

  function automatic logic [31:0] load_id();
    int          r;
    logic [31:0] id;
    r = $urandom_range(0, 99);
    id = $urandom();
    if (r < 60) begin
      id = pool_pick();
    end else if (r < 80) begin
      id = fresh_id();
    end else if (r < 95) begin
      id[7:0] = 8'h00;
    end else begin
      id = '0;
    end
    return id;
  endfunction

  task automatic random_phase(input int count);
    int          r;
    logic [31:0] id;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        clock_ms = clock_ms + $urandom_range(0, (window_ms >> 2) + 1);
      end else if (r < 95) begin
        clock_ms = clock_ms + window_ms + $urandom_range(0, 3);
      end else begin
        clock_ms = $urandom();
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        push_load(8'($urandom_range(0, 255)), load_id());
      end else if (r < 18) begin
        push_card(master_id, clock_ms);
      end else if (r < 50) begin
        push_card(pool_pick(), clock_ms);
      end else if (r < 75) begin
        push_card(fresh_id(), clock_ms);
      end else if (r < 80) begin
        id = $urandom();
        id[7:0] = 8'h00;
        push_card(id, clock_ms);
      end else if (r < 83) begin
        push_card($urandom(), $urandom());
      end else begin
        push_card(pool_pick(), clock_ms);
      end
    end
  endtask

  // Checked between rising edges, once every driver and monitor update has settled.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_config(input logic [31:0] master, input logic [31:0] window);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MASTER_CARD;
    cfg_wdata <= master;
    master_id = master;
    @(posedge clk);
    cfg_idx <= CFG_ENROL_WINDOW;
    cfg_wdata <= window;
    window_ms = window;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: matching, door toggles, enrolment, zero first byte, expiry, wrap.
    push_card(32'h1122_3344, 32'd0);
    push_load(8'd0, 32'h1122_3344);
    push_load(8'd255, 32'hFFFF_FFFF);
    push_card(32'h1122_3344, 32'd10);
    push_card(32'hFFFF_FFFF, 32'd20);
    push_load(8'd3, 32'h00AA_BB00);
    push_card(32'h00AA_BB00, 32'd30);
    push_card(MASTER_CARD_RST, 32'd1000);
    push_card(32'h5566_7788, 32'd2000);
    push_card(32'h1122_3344, 32'd3000);
    push_card(32'h1234_5600, 32'd4000);
    push_card(32'h1234_5600, 32'd5000);
    push_card(32'h5566_7788, 32'd11000);
    push_card(32'hA5A5_A5A5, 32'd11001);
    push_card(MASTER_CARD_RST, 32'hFFFF_FF00);
    push_card(32'h0BAD_CAFE, 32'h0000_0100);
    push_card(32'h5566_7788, 32'h0000_4E30);
    push_card(32'h0000_0000, 32'h0000_5000);
    push_load(8'd0, 32'h0000_0000);
    push_card(32'h1122_3344, 32'h0000_5100);
    push_load(8'd128, 32'h8000_0001);

    set_config(32'hFFFF_FFFF, 32'd0);
    push_card(32'hFFFF_FFFF, 32'h0000_7000);
    push_card(32'h3C3C_3C3C, 32'h0000_7000);
    push_card(32'h3C3C_3C3C, 32'h0000_7001);
    push_card(32'hFFFF_FFFF, 32'h0000_7001);
    clock_ms = 32'h0000_7001;
    random_phase(300);

    // Every slot used, so enrolment finds the store full.
    drain();
    for (int i = 0; i < NSLOTS; i++) begin
      push_load(8'(i), fresh_id());
    end
    set_config(32'h0000_0000, 32'hFFFF_FFFF);
    push_card(32'h0000_0000, 32'h0000_0100);
    push_card(32'h7E57_0001, 32'h0000_0200);
    push_card(pool_pick(), 32'h0000_0300);
    push_card(32'h0000_0000, 32'h0000_0400);
    push_card(32'h1357_9BDF, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FFFF;
    random_phase(250);

    for (int p = 0; p < 4; p++) begin
      set_config(($urandom_range(0, 1) == 0) ? pool_pick() : $urandom(),
                 $urandom_range(100, 5000));
      random_phase(260);
    end

    drain();
    repeat (NSLOTS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
